FILE: src/assert_macros.svh
// Assertion shorthands shared by ofr_root_stage and the top-level module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ofr_pkg.sv
// ----------------------------------------------------------------------------
// ofr_pkg
// Shared widths, limits and vector indexes for the orthonormal frame pipeline.
// ----------------------------------------------------------------------------
package ofr_pkg;

  // Input components after range reduction: magnitude up to 2^15.
  localparam int VEC_W  = 17;
  // Products of two reduced components and their short sums.
  localparam int PROD_W = 34;
  // Widest pre-normalization component (projection-removed second vector).
  localparam int BP_W   = 52;
  // Magnitude after mid reduction: up to 2^31.
  localparam int MAG_W  = 32;
  // Square of a magnitude and the sum of three squares.
  localparam int SQ_W   = 64;
  // Result component width.
  localparam int OUT_W  = 16;

  localparam int LIMIT_IN = 32768;
  localparam longint unsigned LIMIT_MID = 64'h0000_0000_8000_0000;

  // Vector slots through the pipeline.
  localparam int VEC_A = 0;
  localparam int VEC_B = 1;
  localparam int VEC_N = 2;

  typedef logic signed [VEC_W-1:0] vec_comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [BP_W-1:0] wide_comp_t;
  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [SQ_W-1:0] sq_t;
  typedef logic signed [OUT_W-1:0] out_comp_t;

endpackage

FILE: src/ofr_front.sv
// ----------------------------------------------------------------------------
// ofr_front
// Input range reduction, dot/cross products and projection removal, as five
// register stages. Emits the three integer vectors a, b' and a x b.
// ----------------------------------------------------------------------------
module ofr_front #(
  parameter int IN_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [IN_WIDTH-1:0] first [3],
  input  logic signed [IN_WIDTH-1:0] second [3],
  output logic                       out_valid,
  input  logic                       out_ready,
  output ofr_pkg::wide_comp_t        vec_out [3][3]
);

  localparam int SH_W  = $clog2(IN_WIDTH);
  localparam int NSTG  = 5;
  localparam int EXT_W = 33;

  logic [NSTG-1:0] v;
  logic [NSTG:0]   rdy;

  logic signed [IN_WIDTH-1:0] raw [2][3];
  ofr_pkg::vec_comp_t         red [2][3];

  ofr_pkg::vec_comp_t  a0 [3], b0 [3];
  ofr_pkg::vec_comp_t  a1 [3], b1 [3];
  ofr_pkg::prod_t      sq1 [3], ab1 [3], xp1 [6];
  ofr_pkg::vec_comp_t  a2 [3], b2 [3];
  ofr_pkg::prod_t      sa2, dot2, cr2 [3];
  ofr_pkg::vec_comp_t  a3 [3];
  ofr_pkg::prod_t      cr3 [3];
  ofr_pkg::wide_comp_t pb3 [3], pa3 [3];

  assign raw[0] = first;
  assign raw[1] = second;

  always_comb begin
    rdy[NSTG] = out_ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Halve all magnitudes of a vector until none exceeds 2^15.
  always_comb begin : reduce_in
    logic [IN_WIDTH-1:0] mg [3];
    logic [IN_WIDTH-1:0] mx;
    logic [SH_W-1:0]     sh;
    logic [EXT_W-1:0]    t;
    for (int vv = 0; vv < 2; vv++) begin
      mx = '0;
      for (int c = 0; c < 3; c++) begin
        mg[c] = raw[vv][c][IN_WIDTH-1] ? IN_WIDTH'(-raw[vv][c]) : IN_WIDTH'(raw[vv][c]);
        if (mg[c] > mx) begin
          mx = mg[c];
        end
      end
      sh = '0;
      for (int k = IN_WIDTH - 1; k >= 0; k--) begin
        if ((EXT_W'(mx) >> k) <= EXT_W'(ofr_pkg::LIMIT_IN)) begin
          sh = SH_W'(k);
        end
      end
      for (int c = 0; c < 3; c++) begin
        t = EXT_W'(mg[c]) >> sh;
        red[vv][c] = raw[vv][c][IN_WIDTH-1] ? -signed'(t[ofr_pkg::VEC_W-1:0])
                                            : signed'(t[ofr_pkg::VEC_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a0 <= red[0];
      b0 <= red[1];
    end
    if (rdy[1]) begin
      for (int c = 0; c < 3; c++) begin
        sq1[c] <= ofr_pkg::PROD_W'(a0[c]) * ofr_pkg::PROD_W'(a0[c]);
        ab1[c] <= ofr_pkg::PROD_W'(a0[c]) * ofr_pkg::PROD_W'(b0[c]);
      end
      xp1[0] <= ofr_pkg::PROD_W'(a0[1]) * ofr_pkg::PROD_W'(b0[2]);
      xp1[1] <= ofr_pkg::PROD_W'(a0[2]) * ofr_pkg::PROD_W'(b0[1]);
      xp1[2] <= ofr_pkg::PROD_W'(a0[2]) * ofr_pkg::PROD_W'(b0[0]);
      xp1[3] <= ofr_pkg::PROD_W'(a0[0]) * ofr_pkg::PROD_W'(b0[2]);
      xp1[4] <= ofr_pkg::PROD_W'(a0[0]) * ofr_pkg::PROD_W'(b0[1]);
      xp1[5] <= ofr_pkg::PROD_W'(a0[1]) * ofr_pkg::PROD_W'(b0[0]);
      a1 <= a0;
      b1 <= b0;
    end
    if (rdy[2]) begin
      sa2  <= sq1[0] + sq1[1] + sq1[2];
      dot2 <= ab1[0] + ab1[1] + ab1[2];
      for (int c = 0; c < 3; c++) begin
        cr2[c] <= xp1[2*c] - xp1[2*c+1];
      end
      a2 <= a1;
      b2 <= b1;
    end
    if (rdy[3]) begin
      for (int c = 0; c < 3; c++) begin
        pb3[c] <= ofr_pkg::BP_W'(sa2) * ofr_pkg::BP_W'(b2[c]);
        pa3[c] <= ofr_pkg::BP_W'(dot2) * ofr_pkg::BP_W'(a2[c]);
      end
      a3  <= a2;
      cr3 <= cr2;
    end
    if (rdy[4]) begin
      for (int c = 0; c < 3; c++) begin
        vec_out[ofr_pkg::VEC_A][c] <= ofr_pkg::BP_W'(a3[c]);
        vec_out[ofr_pkg::VEC_B][c] <= pb3[c] - pa3[c];
        vec_out[ofr_pkg::VEC_N][c] <= ofr_pkg::BP_W'(cr3[c]);
      end
    end
  end

endmodule

FILE: src/ofr_prep.sv
// ----------------------------------------------------------------------------
// ofr_prep
// Per-vector reduction to 2^31, squared magnitudes and squared norm. Sets up
// the right-hand side of the rounding test for each component. Three stages.
// ----------------------------------------------------------------------------
module ofr_prep #(
  parameter int FRAC_BITS = 15
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ofr_pkg::wide_comp_t               vec_in [3][3],
  output logic                              out_valid,
  input  logic                              out_ready,
  output ofr_pkg::sq_t                      sum_sq [3],
  output logic signed [2*FRAC_BITS+69:0]    rhs [3][3],
  output logic                              neg [3][3],
  output logic                              ok
);

  localparam int SW   = 2 * FRAC_BITS + 70;
  localparam int SH_W = $clog2(ofr_pkg::BP_W);
  localparam int NSTG = 3;

  logic [NSTG-1:0] v;
  logic [NSTG:0]   rdy;

  ofr_pkg::mag_t mag_n [3][3];
  logic [2:0]    nz_n;

  ofr_pkg::mag_t mag0 [3][3];
  logic          neg0 [3][3];
  logic          ok0;
  ofr_pkg::sq_t  sq1 [3][3];
  logic          neg1 [3][3];
  logic          ok1;

  always_comb begin
    rdy[NSTG] = out_ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Halve all magnitudes of a vector until none exceeds 2^31.
  always_comb begin : reduce_mid
    logic [ofr_pkg::BP_W-1:0] mg [3];
    logic [ofr_pkg::BP_W-1:0] mx;
    logic [SH_W-1:0]          sh;
    logic [ofr_pkg::BP_W-1:0] t;
    for (int vv = 0; vv < 3; vv++) begin
      mx = '0;
      for (int c = 0; c < 3; c++) begin
        mg[c] = vec_in[vv][c][ofr_pkg::BP_W-1] ? ofr_pkg::BP_W'(-vec_in[vv][c])
                                               : ofr_pkg::BP_W'(vec_in[vv][c]);
        if (mg[c] > mx) begin
          mx = mg[c];
        end
      end
      sh = '0;
      for (int k = ofr_pkg::BP_W - 1; k >= 0; k--) begin
        if ((mx >> k) <= ofr_pkg::BP_W'(ofr_pkg::LIMIT_MID)) begin
          sh = SH_W'(k);
        end
      end
      for (int c = 0; c < 3; c++) begin
        t = mg[c] >> sh;
        mag_n[vv][c] = t[ofr_pkg::MAG_W-1:0];
      end
      nz_n[vv] = (mx != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      mag0 <= mag_n;
      for (int vv = 0; vv < 3; vv++) begin
        for (int c = 0; c < 3; c++) begin
          neg0[vv][c] <= vec_in[vv][c][ofr_pkg::BP_W-1];
        end
      end
      ok0 <= &nz_n;
    end
    if (rdy[1]) begin
      for (int vv = 0; vv < 3; vv++) begin
        for (int c = 0; c < 3; c++) begin
          sq1[vv][c] <= ofr_pkg::SQ_W'(mag0[vv][c]) * ofr_pkg::SQ_W'(mag0[vv][c]);
        end
      end
      neg1 <= neg0;
      ok1  <= ok0;
    end
    if (rdy[2]) begin
      for (int vv = 0; vv < 3; vv++) begin
        sum_sq[vv] <= sq1[vv][0] + sq1[vv][1] + sq1[vv][2];
        for (int c = 0; c < 3; c++) begin
          rhs[vv][c] <= signed'(SW'(sq1[vv][c]) << (2 * FRAC_BITS + 2));
        end
      end
      neg <= neg1;
      ok  <= ok1;
    end
  end

endmodule

FILE: src/ofr_root_stage.sv
// ----------------------------------------------------------------------------
// ofr_root_stage
// One bit of the rounded v*2^F/|v| search for all nine components. Tracks
// y^2*s and y*s incrementally (y = 2x-1) so each bit needs only shifts, adds
// and one compare.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ofr_root_stage #(
  parameter int FRAC_BITS = 15,
  parameter int BIT       = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ofr_pkg::sq_t                   s_in [3],
  input  logic signed [2*FRAC_BITS+69:0] rhs_in [3][3],
  input  logic signed [2*FRAC_BITS+69:0] acc_in [3][3],
  input  logic signed [2*FRAC_BITS+69:0] lin_in [3][3],
  input  logic [FRAC_BITS:0]             cur_in [3][3],
  input  logic                           neg_in [3][3],
  input  logic                           ok_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ofr_pkg::sq_t                   s_out [3],
  output logic signed [2*FRAC_BITS+69:0] rhs_out [3][3],
  output logic signed [2*FRAC_BITS+69:0] acc_out [3][3],
  output logic signed [2*FRAC_BITS+69:0] lin_out [3][3],
  output logic [FRAC_BITS:0]             cur_out [3][3],
  output logic                           neg_out [3][3],
  output logic                           ok_out
);

  localparam int SW = 2 * FRAC_BITS + 70;

  logic                 v;
  logic signed [SW-1:0] acc_n [3][3];
  logic signed [SW-1:0] lin_n [3][3];
  logic [FRAC_BITS:0]   cur_n [3][3];

  assign in_ready  = !v || out_ready;
  assign out_valid = v;

  // Trial x + 2^BIT moves y by 2^(BIT+1): y^2 s grows by 2^(BIT+2) y s + 4^(BIT+1) s.
  always_comb begin : trial
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] at;
    logic signed [SW-1:0] bt;
    logic                 take;
    for (int vv = 0; vv < 3; vv++) begin
      sx = signed'(SW'(s_in[vv]));
      for (int c = 0; c < 3; c++) begin
        at   = acc_in[vv][c] + (lin_in[vv][c] <<< (BIT + 2)) + (sx <<< (2 * BIT + 2));
        bt   = lin_in[vv][c] + (sx <<< (BIT + 1));
        take = (at <= rhs_in[vv][c]);
        acc_n[vv][c]      = take ? at : acc_in[vv][c];
        lin_n[vv][c]      = take ? bt : lin_in[vv][c];
        cur_n[vv][c]      = cur_in[vv][c];
        cur_n[vv][c][BIT] = take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s_out   <= s_in;
      rhs_out <= rhs_in;
      acc_out <= acc_n;
      lin_out <= lin_n;
      cur_out <= cur_n;
      neg_out <= neg_in;
      ok_out  <= ok_in;
    end
  end

  `ASSERT_NEXT(a_stalled_beat_holds, clk, rst, v && !out_ready, v && $stable(cur_out[0][0]) && $stable(acc_out[1][1]), "stalled root stage lost or changed its beat")

endmodule

FILE: src/ofr_finish.sv
// ----------------------------------------------------------------------------
// ofr_finish
// Applies sign, Q1.15 saturation and the degenerate override; holds the
// result beat for the output channel.
// ----------------------------------------------------------------------------
module ofr_finish #(
  parameter int FRAC_BITS = 15
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FRAC_BITS:0]  cur_in [3][3],
  input  logic                neg_in [3][3],
  input  logic                ok_in,
  output logic                out_valid,
  input  logic                out_ready,
  output ofr_pkg::out_comp_t  comp [3][3],
  output logic                degenerate
);

  localparam int CL_W = 33;
  localparam logic [FRAC_BITS:0]   TOP     = {1'b0, {FRAC_BITS{1'b1}}};
  localparam logic signed [CL_W-1:0] OUT_MAX = 33'sd32767;
  localparam logic signed [CL_W-1:0] OUT_MIN = -33'sd32768;

  logic               v;
  ofr_pkg::out_comp_t comp_n [3][3];

  assign in_ready  = !v || out_ready;
  assign out_valid = v;

  always_comb begin : shape
    logic [FRAC_BITS:0]     lim;
    logic signed [CL_W-1:0] w;
    for (int vv = 0; vv < 3; vv++) begin
      for (int c = 0; c < 3; c++) begin
        lim = (cur_in[vv][c] > TOP) ? TOP : cur_in[vv][c];
        w   = neg_in[vv][c] ? signed'(-CL_W'(cur_in[vv][c])) : signed'(CL_W'(lim));
        if (w > OUT_MAX) begin
          w = OUT_MAX;
        end else if (w < OUT_MIN) begin
          w = OUT_MIN;
        end
        comp_n[vv][c] = ok_in ? signed'(w[ofr_pkg::OUT_W-1:0]) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      comp       <= comp_n;
      degenerate <= !ok_in;
    end
  end

endmodule

FILE: src/orthonormal_frame_from_two_vectors.sv
// ----------------------------------------------------------------------------
// orthonormal_frame_from_two_vectors: Gram-Schmidt frame in Q1.15
// Five product stages, three norm stages, one stage per result bit of the
// rounding search, one out stage.
// Throughput one beat per cycle if unstalled; stalls freeze only full stages.
// Reset is synchronous and clears the stage valid bits; no other state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module orthonormal_frame_from_two_vectors #(
  parameter int IN_WIDTH  = 16,
  parameter int FRAC_BITS = 15
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic signed [IN_WIDTH-1:0] first_x,
  input  logic signed [IN_WIDTH-1:0] first_y,
  input  logic signed [IN_WIDTH-1:0] first_z,
  input  logic signed [IN_WIDTH-1:0] second_x,
  input  logic signed [IN_WIDTH-1:0] second_y,
  input  logic signed [IN_WIDTH-1:0] second_z,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [15:0]         unit_a_x,
  output logic signed [15:0]         unit_a_y,
  output logic signed [15:0]         unit_a_z,
  output logic signed [15:0]         unit_b_x,
  output logic signed [15:0]         unit_b_y,
  output logic signed [15:0]         unit_b_z,
  output logic signed [15:0]         normal_x,
  output logic signed [15:0]         normal_y,
  output logic signed [15:0]         normal_z,
  output logic                       degenerate
);

  localparam int SW  = 2 * FRAC_BITS + 70;
  localparam int NCH = FRAC_BITS + 2;

  logic signed [IN_WIDTH-1:0] first_v [3];
  logic signed [IN_WIDTH-1:0] second_v [3];

  logic                front_ready, front_valid;
  ofr_pkg::wide_comp_t vec_w [3][3];

  logic                 v_c   [NCH];
  logic                 rdy_c [NCH];
  ofr_pkg::sq_t         s_c   [NCH][3];
  logic signed [SW-1:0] rhs_c [NCH][3][3];
  logic signed [SW-1:0] acc_c [NCH][3][3];
  logic signed [SW-1:0] lin_c [NCH][3][3];
  logic [FRAC_BITS:0]   cur_c [NCH][3][3];
  logic                 neg_c [NCH][3][3];
  logic                 ok_c  [NCH];

  logic               fin_ready;
  ofr_pkg::out_comp_t comp [3][3];

  logic frame_zero, unit_a_live;

  assign first_v[0]  = first_x;
  assign first_v[1]  = first_y;
  assign first_v[2]  = first_z;
  assign second_v[0] = second_x;
  assign second_v[1] = second_y;
  assign second_v[2] = second_z;

  assign item_stall = !front_ready;

  ofr_front #(
    .IN_WIDTH(IN_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (front_ready),
    .first     (first_v),
    .second    (second_v),
    .out_valid (front_valid),
    .out_ready (rdy_c[0]),
    .vec_out   (vec_w)
  );

  ofr_prep #(
    .FRAC_BITS(FRAC_BITS)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (rdy_c[0]),
    .vec_in    (vec_w),
    .out_valid (v_c[0]),
    .out_ready (rdy_c[1]),
    .sum_sq    (s_c[0]),
    .rhs       (rhs_c[0]),
    .neg       (neg_c[0]),
    .ok        (ok_c[0])
  );

  // Search starts at x = 0, i.e. y = -1: y^2 s = s and y s = -s.
  for (genvar vv = 0; vv < 3; vv++) begin : g_seed
    for (genvar c = 0; c < 3; c++) begin : g_comp
      assign acc_c[0][vv][c] = signed'(SW'(s_c[0][vv]));
      assign lin_c[0][vv][c] = -signed'(SW'(s_c[0][vv]));
      assign cur_c[0][vv][c] = '0;
    end
  end

  for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_root
    ofr_root_stage #(
      .FRAC_BITS(FRAC_BITS),
      .BIT      (FRAC_BITS - j)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v_c[j]),
      .in_ready  (rdy_c[j+1]),
      .s_in      (s_c[j]),
      .rhs_in    (rhs_c[j]),
      .acc_in    (acc_c[j]),
      .lin_in    (lin_c[j]),
      .cur_in    (cur_c[j]),
      .neg_in    (neg_c[j]),
      .ok_in     (ok_c[j]),
      .out_valid (v_c[j+1]),
      .out_ready (j == FRAC_BITS ? fin_ready : rdy_c[j+2 < NCH ? j+2 : NCH-1]),
      .s_out     (s_c[j+1]),
      .rhs_out   (rhs_c[j+1]),
      .acc_out   (acc_c[j+1]),
      .lin_out   (lin_c[j+1]),
      .cur_out   (cur_c[j+1]),
      .neg_out   (neg_c[j+1]),
      .ok_out    (ok_c[j+1])
    );
  end

  ofr_finish #(
    .FRAC_BITS(FRAC_BITS)
  ) u_finish (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v_c[NCH-1]),
    .in_ready   (fin_ready),
    .cur_in     (cur_c[NCH-1]),
    .neg_in     (neg_c[NCH-1]),
    .ok_in      (ok_c[NCH-1]),
    .out_valid  (result_valid),
    .out_ready  (!result_stall),
    .comp       (comp),
    .degenerate (degenerate)
  );

  assign unit_a_x = comp[ofr_pkg::VEC_A][0];
  assign unit_a_y = comp[ofr_pkg::VEC_A][1];
  assign unit_a_z = comp[ofr_pkg::VEC_A][2];
  assign unit_b_x = comp[ofr_pkg::VEC_B][0];
  assign unit_b_y = comp[ofr_pkg::VEC_B][1];
  assign unit_b_z = comp[ofr_pkg::VEC_B][2];
  assign normal_x = comp[ofr_pkg::VEC_N][0];
  assign normal_y = comp[ofr_pkg::VEC_N][1];
  assign normal_z = comp[ofr_pkg::VEC_N][2];

  assign frame_zero = (unit_a_x == '0) && (unit_a_y == '0) && (unit_a_z == '0) &&
                      (unit_b_x == '0) && (unit_b_y == '0) && (unit_b_z == '0) &&
                      (normal_x == '0) && (normal_y == '0) && (normal_z == '0);
  assign unit_a_live = (unit_a_x != '0) || (unit_a_y != '0) || (unit_a_z != '0);

  `ASSERT_IMPLIES(a_degenerate_is_zero, clk, rst, result_valid && degenerate, frame_zero, "degenerate beat carries nonzero components")
  `ASSERT_IMPLIES(a_unit_a_nonzero, clk, rst, result_valid && !degenerate, unit_a_live, "valid frame has an all-zero first axis")

endmodule
